### hdl/svn_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the vertex normal smoothing block
// no dependencies; used by svn_mem and smooth_vertex_normals
package svn_pkg;

  localparam int SVN_MAX_VERTICES = 1024;

  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_FACE   = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [9:0]         vertex_index;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic [9:0]         corner_a;
    logic [9:0]         corner_b;
    logic [9:0]         corner_c;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
  } vec24_t;

  typedef struct packed {
    logic   pos_we;
    logic   acc_we;
    vec24_t pos;
    vec24_t acc;
  } mem_wr_t;

  typedef struct packed {
    vec24_t pos;
    vec24_t acc;
  } mem_rd_t;

endpackage

### hdl/svn_mem.sv
`timescale 1ns / 1ps
// vertex position and normal accumulator memories, one shared address
// depends on svn_pkg
module svn_mem #(
  parameter int DEPTH = svn_pkg::SVN_MAX_VERTICES,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic [AW-1:0]    addr,
  input  svn_pkg::mem_wr_t wr,
  output svn_pkg::mem_rd_t rd
);
  import svn_pkg::*;

  vec24_t pos_mem [DEPTH];
  vec24_t acc_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.pos_we) begin
      pos_mem[addr] <= wr.pos;
    end
    if (wr.acc_we) begin
      acc_mem[addr] <= wr.acc;
    end
    rd.pos <= pos_mem[addr];
    rd.acc <= acc_mem[addr];
  end

endmodule

### hdl/smooth_vertex_normals.sv
`timescale 1ns / 1ps
// vertex normal smoothing: sequencer, shared multiplier, sqrt and divider
// depends on svn_pkg and svn_mem
//
// usage: items arrive on in_valid/in_ready with an in_item_t payload, and
// every item gives exactly one result on out_valid/out_ready.
// action write vertex stores a position and clears its accumulator.
// action read normal normalizes one accumulator.
// action add face fetches three corners, normalizes both edges and their
// cross product and adds the unit face normal to the corners.
// each normalization uses three squares on the shared multiplier, a square
// root of one bit per cycle (31 steps) and three restoring divisions of one
// quotient bit per cycle (15 steps each).
// in_ready is high only while the sequencer is idle; one item is in work at a
// time. the finished result sits in an output register, so a new item is taken
// while the receiver stalls; a second result waits until the first is taken.
// after reset the accumulators are cleared one entry per cycle, and in_ready
// stays low until every entry is cleared.
module smooth_vertex_normals #(
  parameter int MAX_VERTICES = svn_pkg::SVN_MAX_VERTICES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  svn_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output svn_pkg::out_item_t out_item
);
  import svn_pkg::*;

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  typedef enum logic [17:0] {
    S_CLEAR = 18'h00001,
    S_IDLE  = 18'h00002,
    S_WRV   = 18'h00004,
    S_RD    = 18'h00008,
    S_EDGE  = 18'h00010,
    S_USQ   = 18'h00020,
    S_UCHK  = 18'h00040,
    S_USQRT = 18'h00080,
    S_UDIVI = 18'h00100,
    S_UDIV  = 18'h00200,
    S_UNEXT = 18'h00400,
    S_UDONE = 18'h00800,
    S_CROSS = 18'h01000,
    S_AR    = 18'h02000,
    S_AW    = 18'h04000,
    S_RDN   = 18'h08000,
    S_RDN2  = 18'h10000,
    S_FIN   = 18'h20000
  } state_t;

  function automatic logic [9:0] reduce_idx(input logic [9:0] v);
    logic [26:0] t;
    t = 27'(v);
    for (int k = 9; k >= 0; k--) begin
      if (t >= (27'(MAX_VERTICES) << k)) begin
        t = t - (27'(MAX_VERTICES) << k);
      end
    end
    return t[9:0];
  endfunction

  function automatic logic [30:0] mag31(input logic signed [30:0] v);
    return v[30] ? 31'(-v) : 31'(v);
  endfunction

  // saturating add, flag in the top bit
  function automatic logic [24:0] sat_add(input logic signed [23:0] a,
                                          input logic signed [15:0] d);
    logic signed [24:0] s;
    s = 25'(a) + 25'(d);
    if (s > 25'sd8388607) return {1'b1, 24'h7FFFFF};
    if (s < -25'sd8388608) return {1'b1, 24'h800000};
    return {1'b0, s[23:0]};
  endfunction

  state_t state_r, state_nxt;
  logic [AW-1:0] clr_r;
  logic          out_valid_r;
  out_item_t     out_data_r;

  logic [AW-1:0]      addr_r;
  logic [AW-1:0]      corner_r [3];
  vec24_t             wpos_r;
  vec24_t             p_r [3];
  logic [4:0]         cnt_r;
  logic [1:0]         k_r;
  logic [1:0]         phase_r;
  logic signed [30:0] vec_r [3];
  logic signed [30:0] e2_r [3];
  logic signed [15:0] n_r [3];
  logic signed [15:0] u1_r [3];
  logic signed [15:0] u2_r [3];
  logic signed [15:0] res_r [3];
  logic [1:0]         stat_r;
  logic               sat_r;
  logic [61:0]        s_r;
  logic [61:0]        sv_r, sr_r, sb_r;
  logic [44:0]        rem_r, dv_r;
  logic [14:0]        q_r;

  logic signed [30:0] mul_a, mul_b;
  logic signed [61:0] prod_r;
  logic [61:0]        sq_t;
  logic [AW-1:0]      mem_addr;
  logic [AW-1:0]      cur_corner;
  mem_wr_t            mem_wr;
  mem_rd_t            mem_rd;
  logic [24:0]        add_x, add_y, add_z;
  logic               fin_load;
  logic [2:0]         cr_idx;

  svn_mem #(.DEPTH(MAX_VERTICES), .AW(AW)) u_mem (
    .clk  (clk),
    .addr (mem_addr),
    .wr   (mem_wr),
    .rd   (mem_rd)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_data_r;
  assign fin_load  = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign sq_t      = sr_r + sb_r;
  assign cr_idx    = 3'(cnt_r - 5'd1);

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    cur_corner = corner_r[0];
      2'd1:    cur_corner = corner_r[1];
      default: cur_corner = corner_r[2];
    endcase
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_USQ: begin
        case (cnt_r[1:0])
          2'd0:    begin mul_a = vec_r[0]; mul_b = vec_r[0]; end
          2'd1:    begin mul_a = vec_r[1]; mul_b = vec_r[1]; end
          2'd2:    begin mul_a = vec_r[2]; mul_b = vec_r[2]; end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      S_CROSS: begin
        case (cnt_r[2:0])
          3'd0:    begin mul_a = 31'(u1_r[1]); mul_b = 31'(u2_r[2]); end
          3'd1:    begin mul_a = 31'(u1_r[2]); mul_b = 31'(u2_r[1]); end
          3'd2:    begin mul_a = 31'(u1_r[2]); mul_b = 31'(u2_r[0]); end
          3'd3:    begin mul_a = 31'(u1_r[0]); mul_b = 31'(u2_r[2]); end
          3'd4:    begin mul_a = 31'(u1_r[0]); mul_b = 31'(u2_r[1]); end
          3'd5:    begin mul_a = 31'(u1_r[1]); mul_b = 31'(u2_r[0]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    add_x = sat_add(mem_rd.acc.x, res_r[0]);
    add_y = sat_add(mem_rd.acc.y, res_r[1]);
    add_z = sat_add(mem_rd.acc.z, res_r[2]);
    mem_wr.pos    = wpos_r;
    mem_wr.pos_we = (state_r == S_WRV);
    mem_wr.acc_we = (state_r == S_WRV) || (state_r == S_CLEAR) || (state_r == S_AW);
    if (state_r == S_AW) begin
      mem_wr.acc = '{x: add_x[23:0], y: add_y[23:0], z: add_z[23:0]};
    end else begin
      mem_wr.acc = '0;
    end
    case (state_r)
      S_CLEAR:                     mem_addr = clr_r;
      S_RD, S_AR, S_AW:            mem_addr = cur_corner;
      default:                     mem_addr = addr_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == AW'(MAX_VERTICES - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          case (in_item.action)
            ACT_WRITE: state_nxt = S_WRV;
            ACT_FACE:  state_nxt = S_RD;
            ACT_READ:  state_nxt = S_RDN;
            default:   state_nxt = S_FIN;
          endcase
        end
      end
      S_WRV:   state_nxt = S_FIN;
      S_RD:    if (cnt_r == 5'd3) state_nxt = S_EDGE;
      S_EDGE:  state_nxt = S_USQ;
      S_USQ:   if (cnt_r == 5'd3) state_nxt = S_UCHK;
      S_UCHK:  state_nxt = (s_r == '0) ? S_FIN : S_USQRT;
      S_USQRT: if (cnt_r == 5'd30) state_nxt = S_UDIVI;
      S_UDIVI: state_nxt = S_UDIV;
      S_UDIV:  if (cnt_r == 5'd14) state_nxt = S_UNEXT;
      S_UNEXT: state_nxt = (k_r == 2'd2) ? S_UDONE : S_UDIVI;
      S_UDONE: begin
        case (phase_r)
          2'd0:    state_nxt = S_USQ;
          2'd1:    state_nxt = S_CROSS;
          2'd2:    state_nxt = S_AR;
          default: state_nxt = S_FIN;
        endcase
      end
      S_CROSS: if (cnt_r == 5'd6) state_nxt = S_USQ;
      S_AR:    state_nxt = S_AW;
      S_AW:    state_nxt = (cnt_r == 5'd2) ? S_FIN : S_AR;
      S_RDN:   state_nxt = S_RDN2;
      S_RDN2:  state_nxt = S_USQ;
      S_FIN:   if (fin_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + AW'(1);
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (fin_load) begin
      out_data_r <= '{normal_x: res_r[0], normal_y: res_r[1], normal_z: res_r[2],
                      status: stat_r};
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          addr_r      <= AW'(reduce_idx(in_item.vertex_index));
          corner_r[0] <= AW'(reduce_idx(in_item.corner_a));
          corner_r[1] <= AW'(reduce_idx(in_item.corner_b));
          corner_r[2] <= AW'(reduce_idx(in_item.corner_c));
          wpos_r      <= '{x: in_item.pos_x, y: in_item.pos_y, z: in_item.pos_z};
          res_r[0]    <= '0;
          res_r[1]    <= '0;
          res_r[2]    <= '0;
          stat_r      <= ST_OK;
          sat_r       <= 1'b0;
          cnt_r       <= '0;
        end
      end
      S_RD: begin
        // read data arrives in the cycle after its address
        if (cnt_r != 5'd0) p_r[cnt_r[1:0] - 2'd1] <= mem_rd.pos;
        cnt_r <= cnt_r + 5'd1;
      end
      S_EDGE: begin
        vec_r[0] <= 31'(p_r[1].x) - 31'(p_r[0].x);
        vec_r[1] <= 31'(p_r[1].y) - 31'(p_r[0].y);
        vec_r[2] <= 31'(p_r[1].z) - 31'(p_r[0].z);
        e2_r[0]  <= 31'(p_r[2].x) - 31'(p_r[0].x);
        e2_r[1]  <= 31'(p_r[2].y) - 31'(p_r[0].y);
        e2_r[2]  <= 31'(p_r[2].z) - 31'(p_r[0].z);
        phase_r  <= 2'd0;
        cnt_r    <= '0;
      end
      S_USQ: begin
        if (cnt_r == 5'd1) begin
          s_r <= $unsigned(prod_r);
        end else if (cnt_r != 5'd0) begin
          s_r <= s_r + $unsigned(prod_r);
        end
        cnt_r <= cnt_r + 5'd1;
      end
      S_UCHK: begin
        if (s_r == '0) begin
          res_r[0] <= '0;
          res_r[1] <= '0;
          res_r[2] <= '0;
          stat_r   <= ST_DEGEN;
        end
        sv_r  <= s_r;
        sr_r  <= '0;
        sb_r  <= 62'(1) << 60;
        cnt_r <= '0;
      end
      S_USQRT: begin
        if (sv_r >= sq_t) begin
          sv_r <= sv_r - sq_t;
          sr_r <= (sr_r >> 1) + sb_r;
        end else begin
          sr_r <= sr_r >> 1;
        end
        sb_r  <= sb_r >> 2;
        cnt_r <= cnt_r + 5'd1;
        k_r   <= 2'd0;
      end
      S_UDIVI: begin
        // rounded quotient: (|v| * 2^14 + len/2) / len
        rem_r <= {mag31(vec_r[k_r]), 14'b0} + 45'(sr_r[30:1]);
        dv_r  <= {sr_r[30:0], 14'b0};
        q_r   <= '0;
        cnt_r <= '0;
      end
      S_UDIV: begin
        if (rem_r >= dv_r) begin
          rem_r <= rem_r - dv_r;
          q_r   <= {q_r[13:0], 1'b1};
        end else begin
          q_r   <= {q_r[13:0], 1'b0};
        end
        dv_r  <= dv_r >> 1;
        cnt_r <= cnt_r + 5'd1;
      end
      S_UNEXT: begin
        n_r[k_r] <= vec_r[k_r][30] ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
        k_r      <= k_r + 2'd1;
      end
      S_UDONE: begin
        cnt_r <= '0;
        case (phase_r)
          2'd0: begin
            u1_r    <= n_r;
            vec_r   <= e2_r;
            phase_r <= 2'd1;
          end
          2'd1: begin
            u2_r     <= n_r;
            vec_r[0] <= '0;
            vec_r[1] <= '0;
            vec_r[2] <= '0;
          end
          default: res_r <= n_r;
        endcase
      end
      S_CROSS: begin
        // even products add, odd products subtract
        if (cnt_r != 5'd0) begin
          if (cr_idx[0]) begin
            vec_r[cr_idx[2:1]] <= vec_r[cr_idx[2:1]] - prod_r[30:0];
          end else begin
            vec_r[cr_idx[2:1]] <= vec_r[cr_idx[2:1]] + prod_r[30:0];
          end
        end
        if (cnt_r == 5'd6) begin
          cnt_r   <= '0;
          phase_r <= 2'd2;
        end else begin
          cnt_r <= cnt_r + 5'd1;
        end
      end
      S_AW: begin
        sat_r <= sat_r | add_x[24] | add_y[24] | add_z[24];
        if ((cnt_r == 5'd2) && (sat_r || add_x[24] || add_y[24] || add_z[24])) begin
          stat_r <= ST_SAT;
        end
        cnt_r <= cnt_r + 5'd1;
      end
      S_RDN2: begin
        vec_r[0] <= 31'(mem_rd.acc.x);
        vec_r[1] <= 31'(mem_rd.acc.y);
        vec_r[2] <= 31'(mem_rd.acc.z);
        phase_r  <= 2'd3;
        cnt_r    <= '0;
      end
      default: begin
      end
    endcase
  end

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.normal_x <= 16'sd16384 && out_data_r.normal_x >= -16'sd16384
                  && out_data_r.normal_y <= 16'sd16384 && out_data_r.normal_y >= -16'sd16384
                  && out_data_r.normal_z <= 16'sd16384 && out_data_r.normal_z >= -16'sd16384))
    else $error("normal component out of range");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == ST_DEGEN) |->
      (out_data_r.normal_x == '0 && out_data_r.normal_y == '0 && out_data_r.normal_z == '0))
    else $error("degenerate result with nonzero normal");

  a_sqrt_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_USQRT) |-> $onehot0(sb_r))
    else $error("square root bit not one-hot");

  a_quot_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UNEXT) |-> (q_r <= 15'd16384))
    else $error("quotient exceeds unit length");

endmodule
